@@ hw/rtl/rans_interleaved_encoder_core_defines.svh @@
// Assertion macros used by the rie_checker assertions.
`ifndef RANS_INTERLEAVED_ENCODER_CORE_DEFINES_SVH
`define RANS_INTERLEAVED_ENCODER_CORE_DEFINES_SVH

// Concurrent assertion, masked while reset is asserted.
`define RIE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Concurrent assertion that also holds through reset.
`define RIE_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/rie_pkg.sv @@
// ----------------------------------------------------------------------------
// rie_pkg
// Types and constants of the interleaved rANS encoder core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rie_pkg;

    localparam int STATE_W   = 32;
    localparam int WORD_W    = 16;
    localparam int FREQ_W    = 16;
    localparam int CUMUL_W   = 15;
    localparam int TB_W      = 4;
    localparam int DIV_STEPS = 32;

    localparam logic [STATE_W-1:0] LOWER_BOUND = 32'h0001_0000;
    localparam logic [TB_W-1:0]    TB_MIN      = 4'd10;
    localparam logic [TB_W-1:0]    TB_RESET    = 4'd15;
    localparam logic               REG_TOTAL_BITS = 1'b0;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_RESET  = 2'd3
    } req_t;

    // Per-word control that rides along the divider pipeline.
    typedef struct packed {
        logic [5:0]         lane;
        logic               hold;   // lane is locked until writeback
        logic               wr;     // write the lane state back
        logic               div;    // state comes from the divider
        logic               emit;
        logic               zf;
        logic [WORD_W-1:0]  word;
        logic [STATE_W-1:0] val;    // state_value when no division is used
        logic [TB_W-1:0]    bits;
        logic [CUMUL_W-1:0] cumul;
        logic [FREQ_W-1:0]  freq;
    } rie_ctl_t;

endpackage

@@ hw/rtl/rie_sym_table.sv @@
// ----------------------------------------------------------------------------
// rie_sym_table
// Symbol table memory: frequency and cumulative start, one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rie_sym_table #(
    parameter int SYMBOLS = 256
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [$clog2(SYMBOLS)-1:0]   waddr,
    input  logic [rie_pkg::FREQ_W-1:0]   wfreq,
    input  logic [rie_pkg::CUMUL_W-1:0]  wcumul,
    input  logic                         re,
    input  logic [$clog2(SYMBOLS)-1:0]   raddr,
    output logic [rie_pkg::FREQ_W-1:0]   rfreq,
    output logic [rie_pkg::CUMUL_W-1:0]  rcumul
);
    import rie_pkg::*;

    logic [FREQ_W+CUMUL_W-1:0] mem [SYMBOLS];
    logic [FREQ_W+CUMUL_W-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= {wfreq, wcumul};
        end
        if (re) begin
            rd_reg <= mem[raddr];
        end
    end

    assign rfreq  = rd_reg[FREQ_W+CUMUL_W-1:CUMUL_W];
    assign rcumul = rd_reg[CUMUL_W-1:0];

endmodule

@@ hw/rtl/rie_lane_store.sv @@
// ----------------------------------------------------------------------------
// rie_lane_store
// Lane state memory with valid bits and per-lane busy locks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rie_lane_store #(
    parameter int LANES = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         re,
    input  logic [(LANES>1?$clog2(LANES):1)-1:0] raddr,
    output logic [rie_pkg::STATE_W-1:0]  rdata,
    input  logic                         we,
    input  logic [(LANES>1?$clog2(LANES):1)-1:0] waddr,
    input  logic [rie_pkg::STATE_W-1:0]  wdata,
    input  logic                         lock,
    input  logic [(LANES>1?$clog2(LANES):1)-1:0] lock_idx,
    input  logic                         unlock,
    input  logic [(LANES>1?$clog2(LANES):1)-1:0] unlock_idx,
    output logic [LANES-1:0]             busy
);
    import rie_pkg::*;

    logic [STATE_W-1:0] mem [LANES];
    logic [STATE_W-1:0] rd_reg;
    logic               rd_vld_reg;
    logic [LANES-1:0]   vld_reg;
    logic [LANES-1:0]   busy_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_reg     <= mem[raddr];
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            busy_reg <= '0;
        end else begin
            if (we) begin
                vld_reg[waddr] <= 1'b1;
            end
            if (unlock) begin
                busy_reg[unlock_idx] <= 1'b0;
            end
            if (lock) begin
                busy_reg[lock_idx] <= 1'b1;
            end
        end
    end

    // Unwritten lanes read as the lower bound.
    assign rdata = rd_vld_reg ? rd_reg : LOWER_BOUND;
    assign busy  = busy_reg;

endmodule

@@ hw/rtl/rie_div_stage.sv @@
// ----------------------------------------------------------------------------
// rie_div_stage
// One restoring division step, registered, with pipeline control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rie_div_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        v_in,
    input  rie_pkg::rie_ctl_t           ctl_in,
    input  logic [rie_pkg::STATE_W-1:0] dq_in,
    input  logic [rie_pkg::FREQ_W-1:0]  rem_in,
    output logic                        v_out,
    output rie_pkg::rie_ctl_t           ctl_out,
    output logic [rie_pkg::STATE_W-1:0] dq_out,
    output logic [rie_pkg::FREQ_W-1:0]  rem_out
);
    import rie_pkg::*;

    logic [FREQ_W:0] trial;
    logic            ge;
    logic [FREQ_W:0] diff;

    always_comb begin
        trial = {rem_in, dq_in[STATE_W-1]};
        ge    = trial >= {1'b0, ctl_in.freq};
        diff  = trial - {1'b0, ctl_in.freq};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_out <= 1'b0;
        end else if (en) begin
            v_out <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_out <= ctl_in;
            dq_out  <= {dq_in[STATE_W-2:0], ge};
            rem_out <= ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
        end
    end

endmodule

@@ hw/rtl/rans_interleaved_encoder_core.sv @@
// An accepted word passes stage 1, stage 2, the divider stages and the output register.
// Throughput: one word per cycle while m_tready does not stall the output; a word that
//   reads or writes a lane still in flight waits until that lane's state is written back.
// Latency set by the 32-stage restoring divider, one quotient bit per stage.
// Reset (aresetn low, synchronous): all lanes read as the lower bound,
//   total_bits returns to 15, pipeline empties; the symbol table is not reset.
// ----------------------------------------------------------------------------
// rans_interleaved_encoder_core
// Interleaved rANS encoder: lane states and symbol table in memories, a
// pipelined divider performs the state update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rans_interleaved_encoder_core #(
    parameter int LANES   = 32,
    parameter int SYMBOLS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: lane[4:0], symbol[12:5], freq[28:13], cumul[43:29], zero[47:44]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [1:0]  s_tuser,
    // m_tdata: emit_word[15:0], state_value[47:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // m_tuser: emit_valid[0], zero_freq_error[1]
    output logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rie_pkg::*;

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int SW = $clog2(SYMBOLS);

    // Input field split
    logic [4:0]         in_lane;
    logic [7:0]         in_sym;
    logic [FREQ_W-1:0]  in_freq;
    logic [CUMUL_W-1:0] in_cumul;
    req_t               in_req;
    logic [6:0]         in_lane7;
    logic               in_lane_ok;
    logic               in_sym_ok;
    logic [LW-1:0]      in_lane_idx;

    assign in_lane     = s_tdata[4:0];
    assign in_sym      = s_tdata[12:5];
    assign in_freq     = s_tdata[28:13];
    assign in_cumul    = s_tdata[43:29];
    assign in_req      = req_t'(s_tuser);
    assign in_lane7    = {2'b00, in_lane};
    assign in_lane_ok  = in_lane7 < 7'(LANES);
    assign in_sym_ok   = {1'b0, in_sym} < 9'(SYMBOLS);
    assign in_lane_idx = in_lane7[LW-1:0];

    // Configuration register
    logic [TB_W-1:0] tb_reg;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tb_reg <= TB_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_TOTAL_BITS) begin
            tb_reg <= pwdata[TB_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_TOTAL_BITS) ? {28'd0, tb_reg} : 32'd0;

    // Pipeline enables: a stage advances when it is empty or the next moves.
    logic                 en_out;
    logic                 en_s1;
    logic [DIV_STEPS:0]   en_stg;
    logic [DIV_STEPS:0]   stg_v;
    rie_ctl_t             stg_ctl [DIV_STEPS+1];
    logic [STATE_W-1:0]   stg_dq  [DIV_STEPS+1];
    logic [FREQ_W-1:0]    stg_rem [DIV_STEPS+1];
    logic                 s1_v_reg;
    logic                 m_tvalid_reg;

    assign en_out = !m_tvalid_reg || m_tready;
    assign en_stg[DIV_STEPS] = !stg_v[DIV_STEPS] || en_out;
    genvar gi;
    generate
        for (gi = 0; gi < DIV_STEPS; gi++) begin : g_en
            assign en_stg[gi] = !stg_v[gi] || en_stg[gi+1];
        end
    endgenerate
    assign en_s1 = !s1_v_reg || en_stg[0];

    // Lane interlock: hold any lane access while that lane is in flight.
    logic [LANES-1:0] busy;
    logic             lane_locked;
    logic             accept;
    logic             wb_fire;
    logic [STATE_W-1:0] lane_rd;
    logic [STATE_W-1:0] fin_state;
    rie_ctl_t         fin_ctl;

    assign lane_locked = in_lane_ok && (in_req != REQ_LOAD) && busy[in_lane_idx];
    assign s_tready    = en_s1 && !lane_locked;
    assign accept      = s_tvalid && s_tready;
    assign fin_ctl     = stg_ctl[DIV_STEPS];
    assign wb_fire     = en_out && stg_v[DIV_STEPS];

    rie_lane_store #(.LANES(LANES)) u_lanes (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .re         (en_s1),
        .raddr      (in_lane_idx),
        .rdata      (lane_rd),
        .we         (wb_fire && fin_ctl.wr),
        .waddr      (fin_ctl.lane[LW-1:0]),
        .wdata      (fin_state),
        .lock       (accept && in_lane_ok &&
                     (in_req == REQ_ENCODE || in_req == REQ_RESET)),
        .lock_idx   (in_lane_idx),
        .unlock     (wb_fire && fin_ctl.hold),
        .unlock_idx (fin_ctl.lane[LW-1:0]),
        .busy       (busy)
    );

    // Table loads write at accept; a later encode reads the new entry.
    logic [FREQ_W-1:0]  tab_freq;
    logic [CUMUL_W-1:0] tab_cumul;

    rie_sym_table #(.SYMBOLS(SYMBOLS)) u_table (
        .aclk   (aclk),
        .we     (accept && in_req == REQ_LOAD && in_sym_ok),
        .waddr  (in_sym[SW-1:0]),
        .wfreq  (in_freq),
        .wcumul (in_cumul),
        .re     (en_s1),
        .raddr  (in_sym[SW-1:0]),
        .rfreq  (tab_freq),
        .rcumul (tab_cumul)
    );

    // Stage 1: memory read data arrives here.
    req_t       s1_req_reg;
    logic [5:0] s1_lane_reg;
    logic       s1_lane_ok_reg;
    logic       s1_sym_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (en_s1) begin
            s1_v_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_s1) begin
            s1_req_reg     <= in_req;
            s1_lane_reg    <= in_lane7[5:0];
            s1_lane_ok_reg <= in_lane_ok;
            s1_sym_ok_reg  <= in_sym_ok;
        end
    end

    // Stage 2: renormalization check and divider setup.
    rie_ctl_t           s2_ctl_next;
    logic [STATE_W-1:0] s2_dq_next;
    logic [TB_W-1:0]    bits_eff;
    logic [FREQ_W-1:0]  f_eff;
    logic               enc_ok;
    logic               rst_ok;
    logic               renorm;
    logic [STATE_W-1:0] st_hi;

    always_comb begin
        bits_eff = (tb_reg < TB_MIN) ? TB_MIN : tb_reg;
        f_eff    = s1_sym_ok_reg ? tab_freq : '0;
        enc_ok   = s1_lane_ok_reg && s1_req_reg == REQ_ENCODE;
        rst_ok   = s1_lane_ok_reg && s1_req_reg == REQ_RESET;
        // state >= (2^(16-bits) << 16) * freq  <=>  (state >> (32-bits)) >= freq
        st_hi    = lane_rd >> (6'd32 - {2'b00, bits_eff});
        renorm   = st_hi >= {16'd0, f_eff};

        s2_ctl_next       = '0;
        s2_ctl_next.lane  = s1_lane_reg;
        s2_ctl_next.bits  = bits_eff;
        s2_ctl_next.cumul = tab_cumul;
        s2_ctl_next.freq  = f_eff;
        s2_ctl_next.hold  = enc_ok || rst_ok;
        s2_dq_next        = lane_rd;

        case (s1_req_reg)
            REQ_READ: begin
                if (s1_lane_ok_reg) begin
                    s2_ctl_next.val = lane_rd;
                end
            end
            REQ_RESET: begin
                if (s1_lane_ok_reg) begin
                    s2_ctl_next.val = LOWER_BOUND;
                    s2_ctl_next.wr  = 1'b1;
                end
            end
            REQ_ENCODE: begin
                if (s1_lane_ok_reg) begin
                    if (f_eff == '0) begin
                        s2_ctl_next.zf  = 1'b1;
                        s2_ctl_next.val = lane_rd;
                    end else begin
                        s2_ctl_next.div = 1'b1;
                        s2_ctl_next.wr  = 1'b1;
                        if (renorm) begin
                            s2_ctl_next.emit = 1'b1;
                            s2_ctl_next.word = lane_rd[WORD_W-1:0];
                            s2_dq_next       = {16'd0, lane_rd[STATE_W-1:16]};
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_v[0] <= 1'b0;
        end else if (en_stg[0]) begin
            stg_v[0] <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_stg[0]) begin
            stg_ctl[0] <= s2_ctl_next;
            stg_dq[0]  <= s2_dq_next;
            stg_rem[0] <= '0;
        end
    end

    // Divider: one quotient bit per stage.
    generate
        for (gi = 0; gi < DIV_STEPS; gi++) begin : g_div
            rie_div_stage u_stage (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en_stg[gi+1]),
                .v_in    (stg_v[gi]),
                .ctl_in  (stg_ctl[gi]),
                .dq_in   (stg_dq[gi]),
                .rem_in  (stg_rem[gi]),
                .v_out   (stg_v[gi+1]),
                .ctl_out (stg_ctl[gi+1]),
                .dq_out  (stg_dq[gi+1]),
                .rem_out (stg_rem[gi+1])
            );
        end
    endgenerate

    // Final: new state = (q << bits) + cumul + rem, written back on output load.
    always_comb begin
        fin_state = fin_ctl.val;
        if (fin_ctl.div) begin
            fin_state = (stg_dq[DIV_STEPS] << fin_ctl.bits)
                      + {17'd0, fin_ctl.cumul}
                      + {16'd0, stg_rem[DIV_STEPS]};
        end
    end

    logic [47:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en_out) begin
            m_tvalid_reg <= stg_v[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            m_tdata_reg <= {fin_state, fin_ctl.word};
            m_tuser_reg <= {fin_ctl.zf, fin_ctl.emit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ hw/rtl/rie_checker.sv @@
// ----------------------------------------------------------------------------
// rie_checker
// Port-level checks of the encoder core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rans_interleaved_encoder_core_defines.svh"

module rie_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic [31:0] prdata
);

    `RIE_ASSERT(a_hold_out, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")
    `RIE_ASSERT_ANY(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")
    `RIE_ASSERT(a_emit_no_err, aclk, aresetn, m_tvalid && m_tuser[0] |-> !m_tuser[1], "emit together with zero frequency error")
    `RIE_ASSERT(a_word_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'd0, "emit word nonzero without emit")
    `RIE_ASSERT(a_prdata, aclk, aresetn, prdata[31:4] == 28'd0, "register read has upper bits set")

endmodule

bind rans_interleaved_encoder_core rie_checker u_rie_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .prdata   (prdata)
);

@@ test/rans_lane_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rans_lane_checker
// Watches the input, result and register ports of the rANS encoder core.
// Keeps its own lane states, symbol table and total_bits, predicts one result
// word per accepted input word, and compares results in order.
// ----------------------------------------------------------------------------

module rans_lane_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          outstanding,
    output int          fail_count
);
    import rie_pkg::*;

    typedef struct packed {
        logic               emit_valid;
        logic [WORD_W-1:0]  emit_word;
        logic [STATE_W-1:0] state_value;
        logic               zero_freq_error;
    } enc_result_t;

    logic [STATE_W-1:0] lane_state [32];
    logic [FREQ_W-1:0]  sym_freq   [256];
    logic [CUMUL_W-1:0] sym_cumul  [256];
    logic [TB_W-1:0]    total_bits;
    enc_result_t        result_q [$];

    function automatic enc_result_t encode_word(input req_t req, input logic [47:0] d);
        enc_result_t r;
        logic [4:0]  ln;
        logic [7:0]  sy;
        logic [63:0] st, fq, bound, nxt;
        int          nb;
        ln = d[4:0];
        sy = d[12:5];
        r  = '0;
        case (req)
            REQ_LOAD: begin
                sym_freq[sy]  = d[28:13];
                sym_cumul[sy] = d[43:29];
            end
            REQ_READ: begin
                r.state_value = lane_state[ln];
            end
            REQ_RESET: begin
                lane_state[ln] = LOWER_BOUND;
                r.state_value  = LOWER_BOUND;
            end
            default: begin
                st = 64'(lane_state[ln]);
                fq = 64'(sym_freq[sy]);
                if (fq == 0) begin
                    r.state_value     = st[31:0];
                    r.zero_freq_error = 1'b1;
                end else begin
                    nb    = (total_bits < TB_MIN) ? int'(TB_MIN) : int'(total_bits);
                    bound = ((64'(LOWER_BOUND) >> nb) << 16) * fq;
                    if (st >= bound) begin
                        r.emit_valid = 1'b1;
                        r.emit_word  = st[15:0];
                        st = st >> 16;
                    end
                    nxt = ((st / fq) << nb) + 64'(sym_cumul[sy]) + (st % fq);
                    lane_state[ln] = nxt[31:0];
                    r.state_value  = nxt[31:0];
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        enc_result_t want, got;
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) lane_state[i] = LOWER_BOUND;
            total_bits = TB_RESET;
            result_q.delete();
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == 3'(REG_TOTAL_BITS))
                total_bits = pwdata[TB_W-1:0];
            // retire the oldest expectation before queuing a new one
            if (m_tvalid && m_tready) begin
                got = '{m_tuser[0], m_tdata[15:0], m_tdata[47:16], m_tuser[1]};
                if (result_q.size() == 0) begin
                    $error("unexpected result word: %h/%h", m_tuser, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        if (got.emit_valid !== want.emit_valid)
                            $error("emit_valid: expected %0d, got %0d",
                                   want.emit_valid, got.emit_valid);
                        if (got.emit_word !== want.emit_word)
                            $error("emit_word: expected %h, got %h",
                                   want.emit_word, got.emit_word);
                        if (got.state_value !== want.state_value)
                            $error("state_value: expected %h, got %h",
                                   want.state_value, got.state_value);
                        if (got.zero_freq_error !== want.zero_freq_error)
                            $error("zero_freq_error: expected %0d, got %0d",
                                   want.zero_freq_error, got.zero_freq_error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                result_q.push_back(encode_word(req_t'(s_tuser), s_tdata));
        end
        outstanding <= result_q.size();
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the rANS encoder core with table loads, encodes, lane reads and lane
// resets over several total_bits settings, with random idling on both sides;
// a checker beside the core predicts and compares every result word.
// ----------------------------------------------------------------------------

module testbench;
    import rie_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          outstanding;
    int          fail_count;
    bit          idling_on = 1'b1;  // cleared for the last phase
    bit          loaded [256];      // symbols with a table entry written
    int          cur_bits;          // effective total_bits of the phase

    always #2 aclk = ~aclk;

    rans_interleaved_encoder_core u_dut (.*);

    rans_lane_checker u_check (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .outstanding, .fail_count
    );

    // Result side: stall in random bursts, never in the last phase.
    always @(posedge aclk) begin
        int n;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 14);
            m_tready <= 1'b0;
            repeat (n) @(posedge aclk);
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Send one word and hold it until the handshake completes.
    task automatic send_word(input req_t req, input logic [4:0] ln, input logic [7:0] sy,
                             input logic [15:0] fq, input logic [14:0] cu);
        int gap;
        if (idling_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, cu, fq, sy, ln};
        if (req == REQ_LOAD) loaded[sy] = 1'b1;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    // Register write with a setup and an access phase; only legal while the core is idle.
    task automatic write_total_bits(input logic [3:0] v);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_TOTAL_BITS);
        pwdata  <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!pready);
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_bits = (v < TB_MIN) ? int'(TB_MIN) : int'(v);
    endtask

    // Load a table: 2 to 16 random symbols, frequencies summing to the total.
    task automatic load_table();
        int n, left, cu, f;
        logic [7:0] sy;
        n    = $urandom_range(2, 16);
        left = 1 << cur_bits;
        cu   = 0;
        for (int i = 0; i < n; i++) begin
            sy = 8'($urandom);
            f  = (i == n - 1) ? left : $urandom_range(1, left - (n - 1 - i));
            send_word(REQ_LOAD, 5'd0, sy, 16'(f), 15'(cu));
            cu   += f;
            left -= f;
        end
    endtask

    function automatic logic [7:0] pick_loaded();
        logic [7:0] sy;
        do sy = 8'($urandom); while (!loaded[sy]);
        return sy;
    endfunction

    task automatic random_phase(input int count);
        int k;
        load_table();
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 70)
                send_word(REQ_ENCODE, 5'($urandom), pick_loaded(), 16'($urandom),
                          15'($urandom));
            else if (k < 80)
                send_word(REQ_READ, 5'($urandom), 8'($urandom), 16'($urandom),
                          15'($urandom));
            else if (k < 85)
                send_word(REQ_RESET, 5'($urandom), 8'($urandom), 16'($urandom),
                          15'($urandom));
            else if (k < 97)
                // noise: arbitrary entries, zero and inconsistent ones too
                send_word(REQ_LOAD, 5'($urandom), 8'($urandom), 16'($urandom),
                          15'($urandom));
            else
                load_table();
        end
    endtask

    initial begin
        logic [3:0] bit_plan [6] = '{4'd10, 4'd12, 4'd0, 4'd13, 4'd11, 4'd15};
        cur_bits = 15;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, zero frequency, wrapping table, lane reset.
        send_word(REQ_READ,   5'd0,  8'd0,   16'd0,     15'd0);
        send_word(REQ_READ,   5'd31, 8'd255, 16'hFFFF,  15'h7FFF);
        send_word(REQ_LOAD,   5'd31, 8'd0,   16'd32768, 15'd0);
        send_word(REQ_LOAD,   5'd0,  8'd255, 16'd0,     15'h7FFF);
        send_word(REQ_LOAD,   5'd0,  8'd1,   16'd1,     15'h7FFF);
        send_word(REQ_LOAD,   5'd0,  8'd2,   16'hFFFF,  15'd0);
        send_word(REQ_LOAD,   5'd0,  8'd3,   16'd16384, 15'd16384);
        send_word(REQ_ENCODE, 5'd0,  8'd3,   16'd0,     15'd0);
        send_word(REQ_ENCODE, 5'd0,  8'd3,   16'hFFFF,  15'h7FFF);
        send_word(REQ_ENCODE, 5'd0,  8'd255, 16'd0,     15'd0);
        send_word(REQ_ENCODE, 5'd31, 8'd1,   16'd0,     15'd0);
        send_word(REQ_ENCODE, 5'd31, 8'd1,   16'd0,     15'd0);
        send_word(REQ_ENCODE, 5'd31, 8'd1,   16'd0,     15'd0);
        send_word(REQ_ENCODE, 5'd5,  8'd2,   16'd0,     15'd0);
        send_word(REQ_ENCODE, 5'd5,  8'd2,   16'd0,     15'd0);
        send_word(REQ_READ,   5'd31, 8'd0,   16'd0,     15'd0);
        send_word(REQ_RESET,  5'd31, 8'd0,   16'd0,     15'd0);
        send_word(REQ_READ,   5'd31, 8'd0,   16'd0,     15'd0);
        send_word(REQ_ENCODE, 5'd31, 8'd0,   16'd0,     15'd0);
        send_word(REQ_ENCODE, 5'd7,  8'd0,   16'd0,     15'd0);

        // Random phases over several register settings, the last without idling.
        foreach (bit_plan[p]) begin
            write_total_bits(bit_plan[p]);
            if (p == 5) idling_on = 1'b0;
            random_phase(200);
        end

        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
